// File: src/hidt_pkg.sv
package hidt_pkg;

    localparam int ID_W    = 63;
    localparam int PTR_W   = 64;
    localparam int START_W = 31;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 4;

    // Last ID before the counter wraps to zero
    localparam logic [ID_W-1:0] WRAP_ID = {2'b01, {(ID_W-2){1'b0}}};

    // Register index, taken from paddr bit 3 (8-byte spacing)
    localparam logic REG_START_ID    = 1'b0;
    localparam logic REG_RESERVED_ID = 1'b1;

    typedef enum logic [2:0] {
        OP_ALLOC      = 3'd0,
        OP_PTR_BY_ID  = 3'd1,
        OP_ID_BY_PTR  = 3'd2,
        OP_UPD_BY_ID  = 3'd3,
        OP_UPD_BY_PTR = 3'd4,
        OP_FREE       = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLR,
        S_SCAN
    } t_state;

    // One table slot
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] handle;
        logic [PTR_W-1:0] pointer;
    } t_entry;

    // ID counter status seen by the table sequencer
    typedef struct packed {
        logic [ID_W-1:0] next_id;
        logic            pending;
    } t_ctr_stat;

endpackage

// File: src/hidt_regs.sv
module hidt_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hidt_pkg::ADDR_W-1:0]    paddr,
    input  logic [hidt_pkg::DATA_W-1:0]    pwdata,
    output logic [hidt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_adv,
    output hidt_pkg::t_ctr_stat            o_ctr
);
    import hidt_pkg::*;

    logic [START_W-1:0] r_start;
    logic [ID_W-1:0]    r_reserved;
    logic [ID_W-1:0]    r_next_id;
    logic               r_fix;
    logic [ID_W-1:0]    start_ext;
    logic [ID_W-1:0]    adv_base;
    logic               wr_beat;

    assign pready    = 1'b1;
    assign wr_beat   = psel & penable & pwrite;
    assign start_ext = {{(ID_W-START_W){1'b0}}, pwdata[START_W-1:0]};

    // First half of the counter advance: step or wrap
    assign adv_base = (r_next_id == WRAP_ID) ? '0 : r_next_id + 1'b1;

    // Register readback
    always_comb begin
        if (paddr[3] == REG_RESERVED_ID) begin
            prdata = {{(DATA_W-ID_W){1'b0}}, r_reserved};
        end else begin
            prdata = {{(DATA_W-START_W){1'b0}}, r_start};
        end
    end

    // Config registers and ID counter; reserved skip is the second half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_reserved <= '0;
            r_next_id  <= {{(ID_W-1){1'b0}}, 1'b1};
            r_fix      <= 1'b0;
        end else if (wr_beat) begin
            if (paddr[3] == REG_START_ID) begin
                r_start   <= pwdata[START_W-1:0];
                r_next_id <= (start_ext == r_reserved) ? start_ext + 1'b1 : start_ext;
            end else begin
                r_reserved <= pwdata[ID_W-1:0];
            end
        end else if (i_adv) begin
            r_next_id <= adv_base;
            r_fix     <= 1'b1;
        end else if (r_fix) begin
            r_fix <= 1'b0;
            if (r_next_id == r_reserved) begin
                r_next_id <= r_next_id + 1'b1;
            end
        end
    end

    assign o_ctr.next_id = r_next_id;
    assign o_ctr.pending = r_fix;

endmodule

// File: src/handle_id_table.sv
// Handle ID table: binds incrementing 63-bit handle IDs to 64-bit pointers.
// Command channel: present i_operation and its operands with start high;
// the command is taken on a clock edge where start is high and busy low.
// Every command returns one result beat: o_done is high for exactly one
// cycle with o_status, o_result_id and o_result_pointer. The receiver has
// no way to stall, so it must sample the beat in that cycle.
// Timing: searches and alloc walk the table one slot per cycle through a
// single registered memory read port and one shared compare. The result
// beat follows the slot that decides the command, the last slot on a miss
// or full table, or the end of the sweep for clear; the unused opcode is
// answered from idle. A new command can be taken at the edge that ends the
// result beat; after alloc, busy stays high while the counter runs its
// reserved-ID check.
// Reset: synchronous, active low. After reset the block runs a clearing
// pass over every slot with busy high; APB writes are taken meanwhile.
// Configuration (APB, start_id at 0x0, reserved_id at 0x8) must be written
// only while idle (not enforced); writing start_id reloads the ID counter.
module handle_id_table #(
    parameter int ENTRIES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_operation,
    input  logic [hidt_pkg::ID_W-1:0]      i_handle_id,
    input  logic [hidt_pkg::PTR_W-1:0]     i_pointer_value,
    input  logic [hidt_pkg::PTR_W-1:0]     i_old_pointer,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [hidt_pkg::ID_W-1:0]      o_result_id,
    output logic [hidt_pkg::PTR_W-1:0]     o_result_pointer,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hidt_pkg::ADDR_W-1:0]    paddr,
    input  logic [hidt_pkg::DATA_W-1:0]    pwdata,
    output logic [hidt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import hidt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [ID_W-1:0] r_key_id, n_key_id;
    logic [PTR_W-1:0] r_key_ptr, n_key_ptr;
    logic [PTR_W-1:0] r_old_ptr, n_old_ptr;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_issued, n_issued;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_paddr, n_paddr;
    logic            r_clr_reply, n_clr_reply;
    logic            r_done, n_done;
    t_status         r_status, n_status;
    logic [ID_W-1:0] r_rid, n_rid;
    logic [PTR_W-1:0] r_rptr, n_rptr;

    t_entry          mem [ENTRIES];
    t_entry          r_rd;
    logic            rd_en;
    logic            we;
    logic [AW-1:0]   waddr;
    t_entry          wdata;
    logic            hit;
    logic            adv;
    t_ctr_stat       ctr;

    hidt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_adv   (adv),
        .o_ctr   (ctr)
    );

    assign busy = (r_state != S_IDLE) || ctr.pending;

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd <= mem[r_addr];
        end
    end

    // Slot compare for the operation in flight
    always_comb begin
        case (r_op)
            OP_ALLOC:      hit = !r_rd.valid;
            OP_PTR_BY_ID,
            OP_UPD_BY_ID,
            OP_FREE:       hit = r_rd.valid && (r_rd.handle == r_key_id);
            OP_ID_BY_PTR:  hit = r_rd.valid && (r_rd.pointer == r_key_ptr);
            OP_UPD_BY_PTR: hit = r_rd.valid && (r_rd.pointer == r_old_ptr);
            default:       hit = 1'b0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key_id    = r_key_id;
        n_key_ptr   = r_key_ptr;
        n_old_ptr   = r_old_ptr;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_pend      = 1'b0;
        n_paddr     = r_addr;
        n_clr_reply = r_clr_reply;
        n_done      = 1'b0;
        n_status    = r_status;
        n_rid       = r_rid;
        n_rptr      = r_rptr;
        rd_en       = 1'b0;
        we          = 1'b0;
        waddr       = r_paddr;
        wdata       = r_rd;
        adv         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start && !busy) begin
                    n_op      = t_op'(i_operation);
                    n_key_id  = i_handle_id;
                    n_key_ptr = i_pointer_value;
                    n_old_ptr = i_old_pointer;
                    n_addr    = '0;
                    n_issued  = 1'b0;
                    case (t_op'(i_operation))
                        OP_CLEAR: begin
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        OP_NONE: begin
                            n_done   = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_rid    = '0;
                            n_rptr   = '0;
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end

            // Sweep every slot invalid
            S_CLR: begin
                we    = 1'b1;
                waddr = r_addr;
                wdata = '0;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_rid    = '0;
                        n_rptr   = '0;
                    end
                end
            end

            // Read one slot per cycle, compare the one read last cycle
            S_SCAN: begin
                if (!r_issued) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_addr = r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        n_issued = 1'b1;
                    end
                end
                if (r_pend && hit) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_rid    = r_rd.handle;
                    n_rptr   = '0;
                    case (r_op)
                        OP_ALLOC: begin
                            we     = 1'b1;
                            wdata  = '{valid: 1'b1, handle: ctr.next_id,
                                       pointer: r_key_ptr};
                            n_rid  = ctr.next_id;
                            adv    = 1'b1;
                        end
                        OP_PTR_BY_ID: n_rptr = r_rd.pointer;
                        OP_UPD_BY_ID,
                        OP_UPD_BY_PTR: begin
                            we    = 1'b1;
                            wdata = '{valid: 1'b1, handle: r_rd.handle,
                                      pointer: r_key_ptr};
                        end
                        OP_FREE: begin
                            we    = 1'b1;
                            wdata = '{valid: 1'b0, handle: r_rd.handle,
                                      pointer: r_rd.pointer};
                        end
                        default: ;
                    endcase
                end else if (r_pend && (r_paddr == LAST)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = (r_op == OP_ALLOC) ? ST_FULL : ST_NOT_FOUND;
                    n_rid    = '0;
                    n_rptr   = '0;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_issued    <= 1'b0;
            r_pend      <= 1'b0;
            r_clr_reply <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_clr_reply <= n_clr_reply;
            r_done      <= n_done;
        end
    end

    // Operands and result beat
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key_id  <= n_key_id;
        r_key_ptr <= n_key_ptr;
        r_old_ptr <= n_old_ptr;
        r_paddr   <= n_paddr;
        r_status  <= n_status;
        r_rid     <= n_rid;
        r_rptr    <= n_rptr;
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_result_id      = r_rid;
    assign o_result_pointer = r_rptr;

endmodule
